### sv/key_short_long_press_menu_assert.svh
// assertion macros for the key press menu block
`ifndef KEY_SHORT_LONG_PRESS_MENU_ASSERT_SVH
`define KEY_SHORT_LONG_PRESS_MENU_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define KSLPM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define KSLPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/kslpm_pkg.sv
package kslpm_pkg;

    localparam int unsigned CODE_W  = 3;
    localparam int unsigned KEYS_W  = 4;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [HOLD_W-1:0] LONG_THRESHOLD_RST = 16'd10;
    localparam logic [IDX_W-1:0]  MENU_MAX_RST       = 5'd20;
    localparam logic [IDX_W-1:0]  MENU_MIN_RST       = 5'd1;
    localparam logic [HOLD_W-1:0] HOLD_MAX           = '1;

    localparam logic [CODE_W-1:0] KEY_NONE = 3'd0;
    localparam logic [CODE_W-1:0] KEY_1    = 3'd1;
    localparam logic [CODE_W-1:0] KEY_2    = 3'd2;
    localparam logic [CODE_W-1:0] KEY_3    = 3'd3;
    localparam logic [CODE_W-1:0] KEY_4    = 3'd4;

    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_SCAN = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_THRESHOLD = 2'd0,
        CFG_MENU_MAX       = 2'd1,
        CFG_MENU_MIN       = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [HOLD_W-1:0] long_threshold;
        logic [IDX_W-1:0]  menu_max;
        logic [IDX_W-1:0]  menu_min;
    } t_cfg;

    typedef struct packed {
        logic [CODE_W-1:0] prev_code;
        logic [HOLD_W-1:0] hold_count;
        logic [IDX_W-1:0]  sel_entry;
        logic              in_menu;
        logic [IDX_W-1:0]  run_task;
    } t_state;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic [CODE_W-1:0] short_key;
        logic [CODE_W-1:0] long_key;
        logic [IDX_W-1:0]  menu_index;
        logic              menu_shown;
        logic [IDX_W-1:0]  task_number;
        logic              entered;
        logic              quit;
    } t_result;

    // key 1 has the highest priority
    function automatic logic [CODE_W-1:0] encode_keys(input logic [KEYS_W-1:0] k);
        logic [CODE_W-1:0] c;
        if (k[0])      c = KEY_1;
        else if (k[1]) c = KEY_2;
        else if (k[2]) c = KEY_3;
        else if (k[3]) c = KEY_4;
        else           c = KEY_NONE;
        return c;
    endfunction

endpackage

### sv/kslpm_in_if.sv
interface kslpm_in_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [kslpm_pkg::KEYS_W-1:0]      keys_pressed;

    modport source (output valid, output action, output keys_pressed, input ready);
    modport sink   (input valid, input action, input keys_pressed, output ready);
endinterface

### sv/kslpm_out_if.sv
interface kslpm_out_if;
    logic                              valid;
    logic                              ready;
    logic [kslpm_pkg::CODE_W-1:0]      key_code;
    logic [kslpm_pkg::CODE_W-1:0]      short_key;
    logic [kslpm_pkg::CODE_W-1:0]      long_key;
    logic [kslpm_pkg::IDX_W-1:0]       menu_index;
    logic                              menu_shown;
    logic [kslpm_pkg::IDX_W-1:0]       task_number;
    logic                              entered;
    logic                              quit;

    modport source (
        output valid, output key_code, output short_key, output long_key,
        output menu_index, output menu_shown, output task_number,
        output entered, output quit, input ready
    );
    modport sink (
        input valid, input key_code, input short_key, input long_key,
        input menu_index, input menu_shown, input task_number,
        input entered, input quit, output ready
    );
endinterface

### sv/kslpm_step.sv
module kslpm_step (
    input  kslpm_pkg::t_state              i_state,
    input  kslpm_pkg::t_cfg                i_cfg,
    input  logic                           i_action,
    input  logic [kslpm_pkg::KEYS_W-1:0]   i_keys,
    output kslpm_pkg::t_state              o_state,
    output kslpm_pkg::t_result             o_result
);

    always_comb begin
        logic [kslpm_pkg::CODE_W-1:0] code;
        logic [kslpm_pkg::CODE_W-1:0] diff;
        logic [kslpm_pkg::CODE_W-1:0] up;
        logic [kslpm_pkg::CODE_W-1:0] down;
        logic [kslpm_pkg::HOLD_W-1:0] hold;
        logic [kslpm_pkg::IDX_W:0]    inc;
        logic [kslpm_pkg::IDX_W:0]    min_p1;

        o_state  = i_state;
        o_result = '0;
        code     = kslpm_pkg::KEY_NONE;
        diff     = '0;
        up       = '0;
        down     = '0;
        hold     = i_state.hold_count;
        inc      = {1'b0, i_state.sel_entry} + {{kslpm_pkg::IDX_W{1'b0}}, 1'b1};
        min_p1   = {1'b0, i_cfg.menu_min} + {{kslpm_pkg::IDX_W{1'b0}}, 1'b1};

        if (i_action == kslpm_pkg::ACT_TICK) begin
            if (i_state.hold_count != kslpm_pkg::HOLD_MAX) begin
                o_state.hold_count = i_state.hold_count + 16'd1;
            end
        end else begin
            code = kslpm_pkg::encode_keys(i_keys);
            diff = i_state.prev_code ^ code;
            // bitwise edge patterns on the codes, not on the keys
            up   = ~code & diff;
            down = code & diff;
            o_state.prev_code = code;
            if (down != '0) begin
                hold = '0;
            end
            o_state.hold_count = hold;

            if (hold < i_cfg.long_threshold) begin
                if (up inside {[kslpm_pkg::KEY_1:kslpm_pkg::KEY_4]}) begin
                    o_result.short_key = up;
                    if (i_state.in_menu) begin
                        if (up == kslpm_pkg::KEY_1) begin
                            if (inc >= {1'b0, i_cfg.menu_max}) begin
                                o_state.sel_entry = i_cfg.menu_max;
                            end else begin
                                o_state.sel_entry = inc[kslpm_pkg::IDX_W-1:0];
                            end
                        end else if (up == kslpm_pkg::KEY_2) begin
                            // clamp, including the step down from zero
                            if ({1'b0, i_state.sel_entry} <= min_p1) begin
                                o_state.sel_entry = i_cfg.menu_min;
                            end else begin
                                o_state.sel_entry = i_state.sel_entry - 5'd1;
                            end
                        end
                    end
                end
            end else begin
                o_result.long_key = code;
                if (code == kslpm_pkg::KEY_1) begin
                    if (i_state.in_menu && (i_state.sel_entry != '0)) begin
                        o_state.in_menu   = 1'b0;
                        o_state.run_task  = i_state.sel_entry;
                        o_result.entered  = 1'b1;
                    end
                end else if (code == kslpm_pkg::KEY_2) begin
                    if (!i_state.in_menu) begin
                        o_state.in_menu  = 1'b1;
                        o_state.run_task = '0;
                        o_result.quit    = 1'b1;
                    end
                end
            end
        end

        o_result.key_code    = o_state.prev_code;
        o_result.menu_index  = o_state.sel_entry;
        o_result.menu_shown  = o_state.in_menu;
        o_result.task_number = o_state.run_task;
    end

endmodule

### sv/key_short_long_press_menu.sv
// channel   dir   payload
// i_in      in    action, keys_pressed
// o_out     out   key_code, short_key, long_key, menu_index, menu_shown,
//                 task_number, entered, quit
//
// one item per cycle sustained while o_out is ready; an input transfer reaches
// result valid through the input register, then state update and result register
// the input register lets one more item in while a result waits on o_out
// synchronous active-low reset: settings to defaults, menu shown, state and valid flags zero
// a stalled output holds its result and blocks the input once the input
// register is also full
module key_short_long_press_menu (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    kslpm_in_if.sink                            i_in,
    kslpm_out_if.source                         o_out,
    input  logic                                i_cfg_we,
    input  logic [kslpm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [kslpm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    kslpm_pkg::t_cfg     r_cfg;
    kslpm_pkg::t_state   r_state;
    kslpm_pkg::t_state   n_state;
    kslpm_pkg::t_result  r_out;
    kslpm_pkg::t_result  n_out;
    logic                r_in_valid;
    logic                r_in_action;
    logic [kslpm_pkg::KEYS_W-1:0] r_in_keys;
    logic                r_out_valid;
    logic                advance;
    logic                in_xfer;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_xfer  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_threshold <= kslpm_pkg::LONG_THRESHOLD_RST;
            r_cfg.menu_max       <= kslpm_pkg::MENU_MAX_RST;
            r_cfg.menu_min       <= kslpm_pkg::MENU_MIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kslpm_pkg::CFG_LONG_THRESHOLD: r_cfg.long_threshold <= i_cfg_data;
                kslpm_pkg::CFG_MENU_MAX:
                    r_cfg.menu_max <= i_cfg_data[kslpm_pkg::IDX_W-1:0];
                kslpm_pkg::CFG_MENU_MIN:
                    r_cfg.menu_min <= i_cfg_data[kslpm_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_action <= i_in.action;
            r_in_keys   <= i_in.keys_pressed;
        end
    end

    kslpm_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_action (r_in_action),
        .i_keys   (r_in_keys),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.prev_code  <= kslpm_pkg::KEY_NONE;
            r_state.hold_count <= '0;
            r_state.sel_entry  <= '0;
            r_state.in_menu    <= 1'b1;
            r_state.run_task   <= '0;
            r_out_valid        <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.key_code    = r_out.key_code;
    assign o_out.short_key   = r_out.short_key;
    assign o_out.long_key    = r_out.long_key;
    assign o_out.menu_index  = r_out.menu_index;
    assign o_out.menu_shown  = r_out.menu_shown;
    assign o_out.task_number = r_out.task_number;
    assign o_out.entered     = r_out.entered;
    assign o_out.quit        = r_out.quit;

`include "key_short_long_press_menu_assert.svh"

    `KSLPM_ASSERT_SAME(a_full_blocks, r_in_valid && r_out_valid && !o_out.ready, !i_in.ready, "input taken while both stages are full")
    `KSLPM_ASSERT_SAME(a_enter_hides, r_out_valid && r_out.entered, !r_out.menu_shown && (r_out.task_number == r_out.menu_index) && (r_out.long_key == kslpm_pkg::KEY_1), "task entry left menu state inconsistent")
    `KSLPM_ASSERT_SAME(a_quit_shows, r_out_valid && r_out.quit, r_out.menu_shown && (r_out.task_number == '0) && (r_out.long_key == kslpm_pkg::KEY_2), "task quit left menu state inconsistent")
    `KSLPM_ASSERT_SAME(a_short_long, r_out_valid, (r_out.short_key == '0) || (r_out.long_key == '0), "short and long press in one item")
    `KSLPM_ASSERT_NEXT(a_out_load, advance, r_out_valid && (r_state == $past(n_state)), "result register missed a state update")

endmodule

### test/tb_key_short_long_press_menu.sv
module tb_key_short_long_press_menu;

    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned STALL_CYCLES  = 80;

    // expected state of the press detector and menu, one result per transfer
    class key_menu_scoreboard;
        logic [kslpm_pkg::HOLD_W-1:0] long_threshold;
        logic [kslpm_pkg::IDX_W-1:0]  menu_top;
        logic [kslpm_pkg::IDX_W-1:0]  menu_bottom;
        logic [kslpm_pkg::CODE_W-1:0] last_code;
        logic [kslpm_pkg::HOLD_W-1:0] hold_ticks;
        logic [kslpm_pkg::IDX_W-1:0]  sel_entry;
        logic                         shown;
        logic [kslpm_pkg::IDX_W-1:0]  task_no;
        kslpm_pkg::t_result           menu_result_q[$];
        int                           errors;
        int                           n_checked;
        int                           n_short;
        int                           n_long;
        int                           n_entered;
        int                           n_quit;

        function new();
            long_threshold = kslpm_pkg::LONG_THRESHOLD_RST;
            menu_top       = kslpm_pkg::MENU_MAX_RST;
            menu_bottom    = kslpm_pkg::MENU_MIN_RST;
            last_code      = kslpm_pkg::KEY_NONE;
            hold_ticks     = '0;
            sel_entry      = '0;
            shown          = 1'b1;
            task_no        = '0;
            errors         = 0;
            n_checked      = 0;
            n_short        = 0;
            n_long         = 0;
            n_entered      = 0;
            n_quit         = 0;
        endfunction

        function void set_config(logic [kslpm_pkg::HOLD_W-1:0] thr,
                                 logic [kslpm_pkg::IDX_W-1:0] top,
                                 logic [kslpm_pkg::IDX_W-1:0] bottom);
            long_threshold = thr;
            menu_top       = top;
            menu_bottom    = bottom;
        endfunction

        function int pending();
            return menu_result_q.size();
        endfunction

        function logic [kslpm_pkg::CODE_W-1:0] key_code_of(logic [kslpm_pkg::KEYS_W-1:0] keys);
            logic [kslpm_pkg::CODE_W-1:0] code;
            casez (keys)
                4'b???1: code = kslpm_pkg::KEY_1;
                4'b??10: code = kslpm_pkg::KEY_2;
                4'b?100: code = kslpm_pkg::KEY_3;
                4'b1000: code = kslpm_pkg::KEY_4;
                default: code = kslpm_pkg::KEY_NONE;
            endcase
            return code;
        endfunction

        function void note_transfer(kslpm_pkg::t_action act,
                                    logic [kslpm_pkg::KEYS_W-1:0] keys);
            kslpm_pkg::t_result           r;
            logic [kslpm_pkg::CODE_W-1:0] code;
            logic [kslpm_pkg::CODE_W-1:0] diff;
            logic [kslpm_pkg::CODE_W-1:0] up;
            logic [kslpm_pkg::CODE_W-1:0] down;
            int                           t;
            r = '0;
            if (act == kslpm_pkg::ACT_TICK) begin
                if (hold_ticks != kslpm_pkg::HOLD_MAX) hold_ticks++;
            end else begin
                code = key_code_of(keys);
                diff = last_code ^ code;
                // bitwise release pattern, may name a key other than the released one
                up   = ~code & diff;
                down = code & diff;
                last_code = code;
                if (down != kslpm_pkg::KEY_NONE) hold_ticks = '0;
                if (hold_ticks < long_threshold) begin
                    if (up >= kslpm_pkg::KEY_1 && up <= kslpm_pkg::KEY_4) begin
                        r.short_key = up;
                        n_short++;
                        if (shown) begin
                            if (up == kslpm_pkg::KEY_1) begin
                                t = int'(sel_entry) + 1;
                                if (t >= int'(menu_top)) t = int'(menu_top);
                                sel_entry = t[kslpm_pkg::IDX_W-1:0];
                            end else if (up == kslpm_pkg::KEY_2) begin
                                // clamp, no wrap below zero
                                t = int'(sel_entry) - 1;
                                if (t <= int'(menu_bottom)) t = int'(menu_bottom);
                                sel_entry = t[kslpm_pkg::IDX_W-1:0];
                            end
                        end
                    end
                end else begin
                    r.long_key = code;
                    if (code != kslpm_pkg::KEY_NONE) n_long++;
                    if (code == kslpm_pkg::KEY_1) begin
                        if (shown && sel_entry != '0) begin
                            shown     = 1'b0;
                            task_no   = sel_entry;
                            r.entered = 1'b1;
                            n_entered++;
                        end
                    end else if (code == kslpm_pkg::KEY_2) begin
                        if (!shown) begin
                            task_no = '0;
                            shown   = 1'b1;
                            r.quit  = 1'b1;
                            n_quit++;
                        end
                    end
                end
            end
            r.key_code    = last_code;
            r.menu_index  = sel_entry;
            r.menu_shown  = shown;
            r.task_number = task_no;
            menu_result_q.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch at result %0d: %s", n_checked, what);
            errors++;
        endtask

        task check_field(string name, int got, int want);
            if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_result(kslpm_pkg::t_result got);
            kslpm_pkg::t_result want;
            if (menu_result_q.size() == 0) begin
                report("result with nothing outstanding");
            end else begin
                want = menu_result_q.pop_front();
                check_field("key_code", int'(got.key_code), int'(want.key_code));
                check_field("short_key", int'(got.short_key), int'(want.short_key));
                check_field("long_key", int'(got.long_key), int'(want.long_key));
                check_field("menu_index", int'(got.menu_index), int'(want.menu_index));
                check_field("menu_shown", int'(got.menu_shown), int'(want.menu_shown));
                check_field("task_number", int'(got.task_number), int'(want.task_number));
                check_field("entered", int'(got.entered), int'(want.entered));
                check_field("quit", int'(got.quit), int'(want.quit));
            end
            n_checked++;
        endtask
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [kslpm_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [kslpm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    kslpm_in_if  in_if();
    kslpm_out_if out_if();

    key_menu_scoreboard sb;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_req;
    int stall_ack;
    int stall_left;
    int n_sent;
    int n_settings;

    key_short_long_press_menu dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver: random idling plus long hold-offs on request
    always @(posedge i_clk) begin
        if (stall_req != stall_ack) begin
            stall_ack  = stall_req;
            stall_left = STALL_CYCLES;
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // note input transfers before checking results in case both fall on one edge
    always @(posedge i_clk) begin
        kslpm_pkg::t_result got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_transfer(kslpm_pkg::t_action'(in_if.action), in_if.keys_pressed);
            if (out_if.valid && out_if.ready) begin
                got.key_code    = out_if.key_code;
                got.short_key   = out_if.short_key;
                got.long_key    = out_if.long_key;
                got.menu_index  = out_if.menu_index;
                got.menu_shown  = out_if.menu_shown;
                got.task_number = out_if.task_number;
                got.entered     = out_if.entered;
                got.quit        = out_if.quit;
                sb.check_result(got);
            end
        end
    end

    task automatic send_item(input kslpm_pkg::t_action act,
                             input logic [kslpm_pkg::KEYS_W-1:0] keys);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.action       <= act;
        in_if.keys_pressed <= keys;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [kslpm_pkg::HOLD_W-1:0] thr,
                                input logic [kslpm_pkg::IDX_W-1:0] top,
                                input logic [kslpm_pkg::IDX_W-1:0] bottom);
        logic [kslpm_pkg::CFG_DATA_W-kslpm_pkg::IDX_W-1:0] junk;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= kslpm_pkg::CFG_LONG_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        // upper data bits are don't care for the 5 bit registers
        junk = (kslpm_pkg::CFG_DATA_W - kslpm_pkg::IDX_W)'($urandom);
        i_cfg_idx  <= kslpm_pkg::CFG_MENU_MAX;
        i_cfg_data <= {junk, top};
        @(posedge i_clk);
        junk = (kslpm_pkg::CFG_DATA_W - kslpm_pkg::IDX_W)'($urandom);
        i_cfg_idx  <= kslpm_pkg::CFG_MENU_MIN;
        i_cfg_data <= {junk, bottom};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_config(thr, top, bottom);
        n_settings++;
    endtask

    // press, hold for some ticks with repeated scans, then release or roll over
    task automatic press_sequence();
        logic [kslpm_pkg::KEYS_W-1:0] keys;
        logic [kslpm_pkg::KEYS_W-1:0] low;
        logic [kslpm_pkg::KEYS_W-1:0] upper;
        int                           ticks;
        int                           k;
        keys  = kslpm_pkg::KEYS_W'($urandom_range(1, 15));
        low   = keys & (~keys + 4'd1);
        upper = ~((low << 1) - 4'd1);
        send_item(kslpm_pkg::ACT_SCAN, keys);
        if (sb.long_threshold > 40)
            ticks = $urandom_range(0, 40);
        else if (sb.long_threshold != 0 && $urandom_range(1) == 1)
            ticks = $urandom_range(0, sb.long_threshold - 1);
        else
            ticks = sb.long_threshold + $urandom_range(0, 3);
        for (k = 0; k < ticks; k++) begin
            // extra lower-priority keys keep the same code
            if ($urandom_range(99) < 20)
                send_item(kslpm_pkg::ACT_SCAN,
                          keys | (kslpm_pkg::KEYS_W'($urandom) & upper));
            send_item(kslpm_pkg::ACT_TICK, kslpm_pkg::KEYS_W'($urandom));
        end
        if ($urandom_range(2) == 0) send_item(kslpm_pkg::ACT_SCAN, keys);
        if ($urandom_range(99) < 70) send_item(kslpm_pkg::ACT_SCAN, 4'b0000);
        else send_item(kslpm_pkg::ACT_SCAN, kslpm_pkg::KEYS_W'($urandom));
    endtask

    task automatic run_phase(input logic [kslpm_pkg::HOLD_W-1:0] thr,
                             input logic [kslpm_pkg::IDX_W-1:0] top,
                             input logic [kslpm_pkg::IDX_W-1:0] bottom, input int n_items,
                             input bit hold_off);
        int  first;
        bit  pressed;
        wait_drained();
        write_config(thr, top, bottom);
        first   = n_sent;
        pressed = 1'b0;
        while (n_sent - first < n_items) begin
            if (!pressed && n_sent - first >= n_items / 2) begin
                pressed = 1'b1;
                if (hold_off) stall_req++;
                else wait_drained();
            end
            if ($urandom_range(99) < 85) press_sequence();
            else send_item(kslpm_pkg::t_action'($urandom_range(1)),
                           kslpm_pkg::KEYS_W'($urandom));
        end
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = kslpm_pkg::CFG_LONG_THRESHOLD;
        i_cfg_data    = '0;
        in_if.valid   = 1'b0;
        in_if.action  = kslpm_pkg::ACT_TICK;
        in_if.keys_pressed = '0;
        out_if.ready  = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 82;
        stall_req     = 0;
        stall_ack     = 0;
        stall_left    = 0;
        n_sent        = 0;
        n_settings    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: short presses, decrement from zero, bitwise roll-over
        send_item(kslpm_pkg::ACT_TICK, 4'b0000);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0000);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0010);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0000);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0001);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0000);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0100);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0001);
        send_item(kslpm_pkg::ACT_SCAN, 4'b1000);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0000);
        send_item(kslpm_pkg::ACT_SCAN, 4'b1111);
        send_item(kslpm_pkg::ACT_TICK, 4'b1111);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0000);
        wait_drained();
        // long presses: enter, repeat, release on long path, quit
        write_config(16'd2, 5'd31, 5'd1);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0001);
        send_item(kslpm_pkg::ACT_TICK, 4'b0000);
        send_item(kslpm_pkg::ACT_TICK, 4'b0000);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0011);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0001);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0000);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0010);
        send_item(kslpm_pkg::ACT_TICK, 4'b0000);
        send_item(kslpm_pkg::ACT_TICK, 4'b0000);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0010);
        send_item(kslpm_pkg::ACT_SCAN, 4'b0000);

        run_phase(16'd10, 5'd20, 5'd1, 200, 1'b0);
        run_phase(16'd1, 5'd31, 5'd1, 200, 1'b1);
        run_phase(16'd2, 5'd5, 5'd3, 200, 1'b0);

        send_idle_pct = 82;
        recv_idle_pct = 13;
        run_phase(16'd0, 5'd31, 5'd31, 180, 1'b1);
        run_phase(16'd3, 5'd4, 5'd10, 200, 1'b0);
        run_phase(16'd5, 5'd1, 5'd1, 180, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long threshold at its top value
        run_phase(16'hFFFF, 5'd31, 5'd1, 100, 1'b1);
        run_phase(16'd4, 5'd20, 5'd2, 200, 1'b1);

        wait_drained();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("covered %0d transfers in, %0d results out over %0d register settings",
                 n_sent, sb.n_checked, n_settings);
        $display("seen %0d short, %0d long presses, %0d tasks entered, %0d quits",
                 sb.n_short, sb.n_long, sb.n_entered, sb.n_quit);
        if (sb.errors == 0)
            $display("tb_key_short_long_press_menu: done, clean");
        else
            $display("tb_key_short_long_press_menu: done, errors");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_key_short_long_press_menu: done, errors");
        $finish;
    end

endmodule
